FILE: rtl/core/midpoint_ellipse_points_defines.svh
// Assertion macros shared by the ellipse point generator RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef MIDPOINT_ELLIPSE_POINTS_DEFINES_SVH
`define MIDPOINT_ELLIPSE_POINTS_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked property check, disabled while reset is asserted.
`define MEP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define MEP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MEP_ASSERT(label, clk, rst_n, prop, msg)
`define MEP_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/core/mep_pkg.sv
// Shared types, widths and codes for the midpoint ellipse point generator.
// Used by mep_ctrl, mep_datapath and midpoint_ellipse_points; depends on nothing.
package mep_pkg;

	// Algorithm limits.
	localparam int MAX_POINTS = 4096;
	localparam int RAD_W      = 10;
	localparam int CNT_W      = $clog2(MAX_POINTS) + 1;

	// Field and datapath widths.
	localparam int COORD_W    = 16;
	localparam int PT_W       = 17;
	localparam int OFF_W      = 11;
	localparam int SQ_W       = 21;
	localparam int SLOPE_W    = 34;
	localparam int TERM_W     = 36;
	localparam int DEC_W      = 48;
	localparam int MUL_W      = 24;
	localparam int PROD_W     = 2 * MUL_W;

	// Stream widths, padded to whole bytes.
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;

	// Action codes carried in the input tuser.
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_NEXT  = 1'b1;

	// Rasterization phase.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_REGION1,
		PH_REGION2
	} phase_t;

	// Controller sequencer states.
	typedef enum logic [3:0] {
		ST_READY,
		ST_SQ_A,
		ST_SQ_B,
		ST_MUL_P,
		ST_INIT,
		ST_CHOOSE,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_E4,
		ST_E5,
		ST_E6,
		ST_ADV1,
		ST_ADV2,
		ST_ADV3
	} ctrl_state_t;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_RX,
		OP_SQ_RY,
		OP_MUL_P,
		OP_INIT,
		OP_E_AB,
		OP_E_TX,
		OP_E_BTX,
		OP_E_TY,
		OP_E_ATY,
		OP_E_FIN,
		OP_STEP,
		OP_TERM,
		OP_APPLY
	} dp_op_t;

	// Commands from controller to datapath.
	typedef struct packed {
		dp_op_t     op;
		logic       region2;
		logic       emit;
		logic [1:0] mirror;
		logic       last;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic off_y_zero;
		logic sx_lt_sy;
		logic out_free;
	} dp_status_t;

endpackage

FILE: rtl/core/mep_datapath.sv
// Datapath of the ellipse point generator: shared multiplier, slope and decision
// registers, offsets and the output beat register. Depends on mep_pkg.
module mep_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mep_pkg::dp_cmd_t               cmd,
	output mep_pkg::dp_status_t            status,
	input  logic [mep_pkg::IN_DATA_W-1:0]  in_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mep_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	logic signed [mep_pkg::COORD_W-1:0] cx_q, cy_q;
	logic        [mep_pkg::RAD_W-1:0]   rx_q, ry_q;
	logic        [mep_pkg::OFF_W-1:0]   offx_q;
	logic signed [mep_pkg::OFF_W-1:0]   offy_q;
	logic signed [mep_pkg::SLOPE_W-1:0] sx_q, sy_q;
	logic signed [mep_pkg::DEC_W-1:0]   dec_q;
	logic        [mep_pkg::SQ_W-1:0]    a2_q, b2_q;
	logic signed [mep_pkg::PROD_W-1:0]  prod_q;
	logic signed [mep_pkg::TERM_W-1:0]  term_q;
	logic                               use_sx_q, use_sy_q;
	logic        [mep_pkg::PT_W-1:0]    ox_q, oy_q;
	logic                               olast_q, ovalid_q;

	logic signed [mep_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic        [mep_pkg::OFF_W:0]     tx;
	logic signed [mep_pkg::OFF_W:0]     ty;
	logic signed [mep_pkg::SLOPE_W-1:0] two_a2, two_b2;
	logic signed [mep_pkg::DEC_W-1:0]   prod_x4;
	logic signed [mep_pkg::TERM_W-1:0]  term_sx, term_sy, term_sq;
	logic                               dec_neg, dec_pos;
	logic signed [mep_pkg::PT_W-1:0]    cx_ext, cy_ext, offx_ext, offy_ext;

	// Helper terms shared by several operations.
	assign tx      = {offx_q, 1'b1};
	assign ty      = $signed({offy_q[mep_pkg::OFF_W-1], offy_q}) - 12'sd1;
	assign two_a2  = $signed({{(mep_pkg::SLOPE_W - mep_pkg::SQ_W - 1){1'b0}}, a2_q, 1'b0});
	assign two_b2  = $signed({{(mep_pkg::SLOPE_W - mep_pkg::SQ_W - 1){1'b0}}, b2_q, 1'b0});
	assign prod_x4 = $signed({prod_q[mep_pkg::PROD_W-3:0], 2'b00});
	assign dec_neg = dec_q[mep_pkg::DEC_W-1];
	assign dec_pos = !dec_q[mep_pkg::DEC_W-1] && (dec_q != '0);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			mep_pkg::OP_SQ_RX: begin
				mul_a = $signed({{(mep_pkg::MUL_W - mep_pkg::RAD_W){1'b0}}, rx_q});
				mul_b = mul_a;
			end
			mep_pkg::OP_SQ_RY: begin
				mul_a = $signed({{(mep_pkg::MUL_W - mep_pkg::RAD_W){1'b0}}, ry_q});
				mul_b = mul_a;
			end
			mep_pkg::OP_MUL_P: begin
				mul_a = $signed({{(mep_pkg::MUL_W - mep_pkg::SQ_W){1'b0}}, a2_q});
				mul_b = $signed({{(mep_pkg::MUL_W - mep_pkg::RAD_W){1'b0}}, ry_q});
			end
			mep_pkg::OP_E_AB: begin
				mul_a = $signed({{(mep_pkg::MUL_W - mep_pkg::SQ_W){1'b0}}, a2_q});
				mul_b = $signed({{(mep_pkg::MUL_W - mep_pkg::SQ_W){1'b0}}, b2_q});
			end
			mep_pkg::OP_E_TX: begin
				mul_a = $signed({{(mep_pkg::MUL_W - mep_pkg::OFF_W - 1){1'b0}}, tx});
				mul_b = mul_a;
			end
			mep_pkg::OP_E_BTX: begin
				mul_a = $signed({{(mep_pkg::MUL_W - mep_pkg::SQ_W){1'b0}}, b2_q});
				mul_b = prod_q[mep_pkg::MUL_W-1:0];
			end
			mep_pkg::OP_E_TY: begin
				mul_a = $signed({{(mep_pkg::MUL_W - mep_pkg::OFF_W - 1){ty[mep_pkg::OFF_W]}}, ty});
				mul_b = mul_a;
			end
			mep_pkg::OP_E_ATY: begin
				mul_a = $signed({{(mep_pkg::MUL_W - mep_pkg::SQ_W){1'b0}}, a2_q});
				mul_b = prod_q[mep_pkg::MUL_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Parts of the decision increment, picked by the branch taken in the step.
	assign term_sx = use_sx_q ? $signed({{(mep_pkg::TERM_W - mep_pkg::SLOPE_W){sx_q[mep_pkg::SLOPE_W-1]}},
		sx_q}) : '0;
	assign term_sy = use_sy_q ? $signed({{(mep_pkg::TERM_W - mep_pkg::SLOPE_W){sy_q[mep_pkg::SLOPE_W-1]}},
		sy_q}) : '0;
	assign term_sq = $signed({{(mep_pkg::TERM_W - mep_pkg::SQ_W){1'b0}}, cmd.region2 ? a2_q : b2_q});

	// Algorithm registers; payload only, no reset needed.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			mep_pkg::OP_LOAD: begin
				cx_q   <= $signed(in_data[15:0]);
				cy_q   <= $signed(in_data[31:16]);
				rx_q   <= in_data[41:32];
				ry_q   <= in_data[51:42];
				offx_q <= '0;
				offy_q <= $signed({1'b0, in_data[51:42]});
				sx_q   <= '0;
			end
			mep_pkg::OP_SQ_RY: begin
				a2_q <= prod_q[mep_pkg::SQ_W-1:0];
			end
			mep_pkg::OP_MUL_P: begin
				b2_q <= prod_q[mep_pkg::SQ_W-1:0];
			end
			mep_pkg::OP_INIT: begin
				sy_q  <= $signed({prod_q[mep_pkg::SLOPE_W-2:0], 1'b0});
				dec_q <= $signed({{(mep_pkg::DEC_W - mep_pkg::SQ_W - 2){1'b0}}, b2_q, 2'b00})
					- prod_x4 + $signed({{(mep_pkg::DEC_W - mep_pkg::SQ_W){1'b0}}, a2_q});
			end
			mep_pkg::OP_E_TX: begin
				dec_q <= -prod_x4;
			end
			mep_pkg::OP_E_TY: begin
				dec_q <= dec_q + prod_q;
			end
			mep_pkg::OP_E_FIN: begin
				dec_q <= dec_q + prod_x4;
			end
			mep_pkg::OP_STEP: begin
				if (!cmd.region2) begin
					offx_q   <= offx_q + 11'd1;
					sx_q     <= sx_q + two_b2;
					use_sx_q <= 1'b1;
					use_sy_q <= !dec_neg;
					if (!dec_neg) begin
						offy_q <= offy_q - 11'sd1;
						sy_q   <= sy_q - two_a2;
					end
				end else begin
					offy_q   <= offy_q - 11'sd1;
					sy_q     <= sy_q - two_a2;
					use_sx_q <= !dec_pos;
					use_sy_q <= 1'b1;
					if (!dec_pos) begin
						offx_q <= offx_q + 11'd1;
						sx_q   <= sx_q + two_b2;
					end
				end
			end
			mep_pkg::OP_TERM: begin
				term_q <= term_sx - term_sy + term_sq;
			end
			mep_pkg::OP_APPLY: begin
				dec_q <= dec_q + $signed({{(mep_pkg::DEC_W - mep_pkg::TERM_W - 2){term_q[mep_pkg::TERM_W-1]}},
					term_q, 2'b00});
			end
			default: begin
			end
		endcase
	end

	// Mirrored point for the output beat.
	assign cx_ext   = $signed({cx_q[mep_pkg::COORD_W-1], cx_q});
	assign cy_ext   = $signed({cy_q[mep_pkg::COORD_W-1], cy_q});
	assign offx_ext = $signed({{(mep_pkg::PT_W - mep_pkg::OFF_W){1'b0}}, offx_q});
	assign offy_ext = $signed({{(mep_pkg::PT_W - mep_pkg::OFF_W){offy_q[mep_pkg::OFF_W-1]}}, offy_q});

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ox_q    <= cmd.mirror[0] ? cx_ext - offx_ext : cx_ext + offx_ext;
			oy_q    <= cmd.mirror[1] ? cy_ext - offy_ext : cy_ext + offy_ext;
			olast_q <= cmd.last;
		end
	end

	// Output beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(mep_pkg::OUT_DATA_W - 2 * mep_pkg::PT_W){1'b0}}, oy_q, ox_q};
	assign m_tlast  = olast_q;

	// Status toward the controller.
	assign status.off_y_zero = (offy_q == '0);
	assign status.sx_lt_sy   = (sx_q < sy_q);
	assign status.out_free   = !ovalid_q || m_tready;

endmodule

FILE: rtl/core/mep_ctrl.sv
// Controller of the ellipse point generator: sequencer, phase, mirror index and
// point count. Depends on mep_pkg; drives mep_datapath through dp_cmd_t.
module mep_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                action,
	input  mep_pkg::dp_status_t status,
	output mep_pkg::dp_cmd_t    cmd
);

	mep_pkg::ctrl_state_t      state_q, state_d;
	mep_pkg::phase_t           phase_q, phase_d;
	logic [1:0]                mirror_q, mirror_d;
	logic [mep_pkg::CNT_W-1:0] count_q, count_d;
	logic [mep_pkg::CNT_W:0]   count_inc;
	logic                      accept;
	logic                      last;

	// Sequencer and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mep_pkg::ST_READY;
			phase_q  <= mep_pkg::PH_IDLE;
			mirror_q <= '0;
			count_q  <= '0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			mirror_q <= mirror_d;
			count_q  <= count_d;
		end
	end

	assign s_tready  = (state_q == mep_pkg::ST_READY) && status.out_free;
	assign accept    = s_tvalid && s_tready;
	assign count_inc = {1'b0, count_q} + 1'b1;
	assign last      = ((phase_q == mep_pkg::PH_REGION2) && (mirror_q == 2'd3) && status.off_y_zero)
		|| (count_inc >= (mep_pkg::CNT_W + 1)'(mep_pkg::MAX_POINTS));

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		mirror_d    = mirror_q;
		count_d     = count_q;
		cmd.op      = mep_pkg::OP_NONE;
		cmd.region2 = (phase_q == mep_pkg::PH_REGION2);
		cmd.emit    = 1'b0;
		cmd.mirror  = mirror_q;
		cmd.last    = last;
		case (state_q)
			mep_pkg::ST_READY: begin
				if (accept && (action == mep_pkg::ACT_START)) begin
					cmd.op   = mep_pkg::OP_LOAD;
					phase_d  = mep_pkg::PH_IDLE;
					mirror_d = '0;
					count_d  = '0;
					state_d  = mep_pkg::ST_SQ_A;
				end else if (accept && (phase_q != mep_pkg::PH_IDLE)) begin
					cmd.emit = 1'b1;
					count_d  = count_inc[mep_pkg::CNT_W-1:0];
					if (last) begin
						phase_d = mep_pkg::PH_IDLE;
					end else if (mirror_q != 2'd3) begin
						mirror_d = mirror_q + 2'd1;
					end else begin
						mirror_d = '0;
						state_d  = mep_pkg::ST_ADV1;
					end
				end
			end
			mep_pkg::ST_SQ_A: begin
				cmd.op  = mep_pkg::OP_SQ_RX;
				state_d = mep_pkg::ST_SQ_B;
			end
			mep_pkg::ST_SQ_B: begin
				cmd.op  = mep_pkg::OP_SQ_RY;
				state_d = mep_pkg::ST_MUL_P;
			end
			mep_pkg::ST_MUL_P: begin
				cmd.op  = mep_pkg::OP_MUL_P;
				state_d = mep_pkg::ST_INIT;
			end
			mep_pkg::ST_INIT: begin
				cmd.op  = mep_pkg::OP_INIT;
				state_d = mep_pkg::ST_CHOOSE;
			end
			mep_pkg::ST_CHOOSE: begin
				if (status.sx_lt_sy) begin
					phase_d = mep_pkg::PH_REGION1;
					state_d = mep_pkg::ST_READY;
				end else begin
					state_d = mep_pkg::ST_E1;
				end
			end
			mep_pkg::ST_E1: begin
				cmd.op  = mep_pkg::OP_E_AB;
				state_d = mep_pkg::ST_E2;
			end
			mep_pkg::ST_E2: begin
				cmd.op  = mep_pkg::OP_E_TX;
				state_d = mep_pkg::ST_E3;
			end
			mep_pkg::ST_E3: begin
				cmd.op  = mep_pkg::OP_E_BTX;
				state_d = mep_pkg::ST_E4;
			end
			mep_pkg::ST_E4: begin
				cmd.op  = mep_pkg::OP_E_TY;
				state_d = mep_pkg::ST_E5;
			end
			mep_pkg::ST_E5: begin
				cmd.op  = mep_pkg::OP_E_ATY;
				state_d = mep_pkg::ST_E6;
			end
			mep_pkg::ST_E6: begin
				cmd.op  = mep_pkg::OP_E_FIN;
				phase_d = mep_pkg::PH_REGION2;
				state_d = mep_pkg::ST_READY;
			end
			mep_pkg::ST_ADV1: begin
				cmd.op  = mep_pkg::OP_STEP;
				state_d = mep_pkg::ST_ADV2;
			end
			mep_pkg::ST_ADV2: begin
				cmd.op  = mep_pkg::OP_TERM;
				state_d = mep_pkg::ST_ADV3;
			end
			mep_pkg::ST_ADV3: begin
				cmd.op = mep_pkg::OP_APPLY;
				// Region 1 leaves for region 2 once the x slope catches up.
				if ((phase_q == mep_pkg::PH_REGION1) && !status.sx_lt_sy) begin
					state_d = mep_pkg::ST_E1;
				end else begin
					state_d = mep_pkg::ST_READY;
				end
			end
			default: begin
				state_d = mep_pkg::ST_READY;
			end
		endcase
	end

endmodule

FILE: rtl/core/midpoint_ellipse_points.sv
// Start beat: ST_SQ_A to ST_CHOOSE set up on the shared 24x24 multiplier; ST_E1 to ST_E6 follow
// if region 2 starts at once. Next beat: its point is on m_tvalid in the cycle after acceptance;
// a step's four mirrored points take a next beat each; ST_ADV1 to ST_ADV3 then update the step,
// plus ST_E1 to ST_E6 when region 2 begins. A result waiting on m_tready holds off the input.
// arst_n clears the sequencer, phase, mirror index, point count and output valid.
module midpoint_ellipse_points (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// center_x[15:0], center_y[31:16], radius_x[41:32], radius_y[51:42], zero pad
	input  logic [mep_pkg::IN_DATA_W-1:0]  s_tdata,
	// action[0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// point_x[16:0], point_y[33:17], zero pad
	output logic [mep_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	`include "midpoint_ellipse_points_defines.svh"

	mep_pkg::dp_cmd_t    cmd;
	mep_pkg::dp_status_t status;

	// Sequencer.
	mep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and output beat register.
	mep_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// A stalled output beat blocks the input side.
	`MEP_ASSERT_NEVER(a_no_accept_when_blocked, clk, arst_n, s_tready && m_tvalid && !m_tready, "input ready while output beat is stalled")

	// A start beat launches the setup sequence, so the next cycle is not ready.
	`MEP_ASSERT(a_start_busy, clk, arst_n, (s_tvalid && s_tready && (s_tuser == mep_pkg::ACT_START)) |=> !s_tready, "ready right after a start beat")

	// A new output beat only follows an accepted next beat.
	`MEP_ASSERT(a_out_from_next, clk, arst_n, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == mep_pkg::ACT_NEXT)), "output beat without a next request")

endmodule

FILE: test/midpoint_ellipse_points_tb.sv
// Self-checking testbench for midpoint_ellipse_points: drives start and next beats and checks
// every outline point against an ellipse predictor held in a small scoreboard class.
// Depends on mep_pkg and the midpoint_ellipse_points RTL only.
module midpoint_ellipse_points_tb;
	import mep_pkg::*;

	localparam int RUN_LIMIT   = 4_000_000;
	localparam int TAIL_CYCLES = 20;
	localparam int DRAIN_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_WORK = 1280;

	// One outline point as the block should emit it.
	typedef struct {
		logic [PT_W-1:0] px;
		logic [PT_W-1:0] py;
		logic            is_last;
	} outline_point_t;

	// Ellipse predictor plus the queue of points still owed by the block.
	class ellipse_scoreboard;
		outline_point_t owed_points[$];
		phase_t         ph = PH_IDLE;
		logic [1:0]     quad = 2'd0;
		longint         ox, oy, sx, sy, dec, a2, b2, ccol, crow;
		int             emitted;
		int             mismatches, checked, starts, idle_nexts, outlines_done, caps;

		function bit busy();
			return ph != PH_IDLE;
		endfunction

		function int pending();
			return owed_points.size();
		endfunction

		task report(input string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("ERROR @%0t: %s", $time, msg);
		endtask

		// Stay in region 1 while the slope is shallow, otherwise reseed the decision for region 2.
		function void pick_region();
			longint tx, ty;
			if (sx < sy) begin
				ph = PH_REGION1;
			end else begin
				tx = 2 * ox + 1;
				ty = oy - 1;
				dec = b2 * tx * tx + 4 * a2 * ty * ty - 4 * a2 * b2;
				ph = PH_REGION2;
			end
		endfunction

		// Update the predicted state for one accepted beat; returns 0 when the beat is ignored.
		function bit note_input(input logic act, input logic signed [COORD_W-1:0] cx,
				input logic signed [COORD_W-1:0] cy, input logic [RAD_W-1:0] rx,
				input logic [RAD_W-1:0] ry);
			outline_point_t p;
			longint rxl, ryl;
			if (act == ACT_START) begin
				rxl = rx;
				ryl = ry;
				ccol = cx;
				crow = cy;
				a2 = rxl * rxl;
				b2 = ryl * ryl;
				ox = 0;
				oy = ryl;
				quad = 2'd0;
				emitted = 0;
				sx = 0;
				sy = 2 * a2 * ryl;
				dec = 4 * b2 - 4 * a2 * ryl + a2;
				pick_region();
				starts++;
				return 1'b1;
			end
			if (ph == PH_IDLE) begin
				idle_nexts++;
				return 1'b0;
			end

			// Mirror the current step into one of the four quadrants.
			p.px = PT_W'(quad[0] ? ccol - ox : ccol + ox);
			p.py = PT_W'(quad[1] ? crow - oy : crow + oy);
			p.is_last = (ph == PH_REGION2 && quad == 2'd3 && oy == 0);
			if (p.is_last)
				outlines_done++;
			emitted++;
			if (emitted >= MAX_POINTS) begin
				if (!p.is_last)
					caps++;
				p.is_last = 1'b1;
			end

			// After the fourth mirror, advance the midpoint step.
			if (quad != 2'd3) begin
				quad++;
			end else begin
				quad = 2'd0;
				if (ph == PH_REGION1) begin
					ox++;
					sx += 2 * b2;
					if (dec < 0) begin
						dec += 4 * (sx + b2);
					end else begin
						oy--;
						sy -= 2 * a2;
						dec += 4 * (sx - sy + b2);
					end
					pick_region();
				end else begin
					oy--;
					sy -= 2 * a2;
					if (dec > 0) begin
						dec += 4 * (a2 - sy);
					end else begin
						ox++;
						sx += 2 * b2;
						dec += 4 * (sx - sy + a2);
					end
					if (oy < 0)
						ph = PH_IDLE;
				end
			end
			if (p.is_last)
				ph = PH_IDLE;
			owed_points.push_back(p);
			return 1'b1;
		endfunction

		// Compare one output beat with the oldest owed point.
		task check_result(input logic [OUT_DATA_W-1:0] data, input logic lst);
			outline_point_t want;
			if (owed_points.size() == 0) begin
				report($sformatf("point beat with none owed: x=%0d y=%0d last=%0b",
					$signed(data[PT_W-1:0]), $signed(data[2*PT_W-1:PT_W]), lst));
				return;
			end
			want = owed_points.pop_front();
			checked++;
			if (data[PT_W-1:0] !== want.px)
				report($sformatf("point %0d: x=%0d, want %0d", checked,
					$signed(data[PT_W-1:0]), $signed(want.px)));
			if (data[2*PT_W-1:PT_W] !== want.py)
				report($sformatf("point %0d: y=%0d, want %0d", checked,
					$signed(data[2*PT_W-1:PT_W]), $signed(want.py)));
			if (lst !== want.is_last)
				report($sformatf("point %0d: last=%0b, want %0b", checked, lst, want.is_last));
			if (data[OUT_DATA_W-1:2*PT_W] !== '0)
				report($sformatf("point %0d: pad bits %0h not zero", checked,
					data[OUT_DATA_W-1:2*PT_W]));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	ellipse_scoreboard sb = new();
	int  work_beats;
	bit  tx_steady;
	bit  rx_steady;
	bit  hold_request;

	midpoint_ellipse_points DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// Offer one input beat at the falling edge and hold it until accepted.
	task automatic send_item(input logic act, input logic signed [COORD_W-1:0] cx,
			input logic signed [COORD_W-1:0] cy, input logic [RAD_W-1:0] rx,
			input logic [RAD_W-1:0] ry);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(IN_DATA_W - 2 * COORD_W - 2 * RAD_W){1'b0}}, ry, rx, cy, cx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (sb.note_input(act, cx, cy, rx, ry))
			work_beats++;
	endtask

	// Next beats carry random payload, which the block must ignore.
	task automatic send_next();
		send_item(ACT_NEXT, COORD_W'($urandom), COORD_W'($urandom),
			RAD_W'($urandom_range(0, 1023)), RAD_W'($urandom_range(0, 1023)));
	endtask

	task automatic finish_outline();
		while (sb.busy())
			send_next();
	endtask

	// Drop valid and wait until every owed point has come out, then let the block settle.
	task automatic drain_points();
		int waited;
		@(negedge clk);
		s_tvalid <= 1'b0;
		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// One random sequence: mostly a start and its points, sometimes broken off or pure noise.
	task automatic random_sequence();
		logic [RAD_W-1:0] rx, ry;
		int r;
		tx_steady = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 4))
				send_item(1'($urandom_range(0, 1)), COORD_W'($urandom), COORD_W'($urandom),
					RAD_W'($urandom_range(0, 1023)), RAD_W'($urandom_range(0, 1023)));
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 80) begin
			rx = RAD_W'($urandom_range(0, 12));
			ry = RAD_W'($urandom_range(0, 12));
		end else if (r < 95) begin
			rx = RAD_W'($urandom_range(0, 40));
			ry = RAD_W'($urandom_range(0, 40));
		end else begin
			rx = RAD_W'($urandom_range(0, 1023));
			ry = RAD_W'($urandom_range(0, 1023));
		end
		send_item(ACT_START, COORD_W'($urandom), COORD_W'($urandom), rx, ry);
		if ($urandom_range(0, 3) != 0 && rx <= 40 && ry <= 40) begin
			finish_outline();
			repeat ($urandom_range(0, 2)) send_next();
		end else begin
			// Broken off: the next start lands while the outline is still running.
			repeat ($urandom_range(0, 40)) send_next();
		end
	endtask

	// Output side: random stalls, steady stretches, and one long hold-off on request.
	initial begin
		int stall_left;
		m_tready = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 149) == 0)
				rx_steady = !rx_steady;
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_steady)
					stall_left = pick_gap();
			end
		end
	end

	// Check every accepted output beat.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
	end

	initial begin
		#(RUN_LIMIT);
		$display("midpoint_ellipse_points regression: fail");
		$finish;
	end

	initial begin
		int random_start;
		bit held, paused;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_START;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: next while idle, degenerate radii, centre extremes, restart while busy.
		send_next();
		send_item(ACT_START, 16'h7fff, 16'h8000, 10'd0, 10'd0);
		finish_outline();
		send_next();
		send_item(ACT_START, 16'h8000, 16'h7fff, 10'd5, 10'd0);
		finish_outline();
		send_item(ACT_START, 16'h0000, 16'h0000, 10'd0, 10'd4);
		finish_outline();
		send_item(ACT_START, 16'sd100, -16'sd100, 10'd3, 10'd2);
		repeat (3) send_next();
		send_item(ACT_START, -16'sd100, 16'sd100, 10'd2, 10'd3);
		finish_outline();

		// Largest radii at the centre corner: points need all 17 bits, then a restart cuts in.
		send_item(ACT_START, 16'h7fff, 16'h7fff, 10'd1023, 10'd1023);
		repeat (40) send_next();

		// Random sequences, with one long output hold-off and one full pause on the way.
		random_start = work_beats;
		held = 1'b0;
		paused = 1'b0;
		while (work_beats - random_start < RANDOM_WORK) begin
			if (!held && work_beats - random_start > RANDOM_WORK / 4) begin
				held = 1'b1;
				hold_request = 1'b1;
			end
			if (!paused && work_beats - random_start > 2 * RANDOM_WORK / 3) begin
				paused = 1'b1;
				drain_points();
			end
			random_sequence();
		end

		drain_points();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d owed points never came out", sb.pending()));
		$display("Ran %0d outline starts and checked %0d points: %0d outlines ended, %0d capped.",
			sb.starts, sb.checked, sb.outlines_done, sb.caps);
		$display("Next beats while idle: %0d; mismatches: %0d.", sb.idle_nexts, sb.mismatches);
		if (sb.mismatches == 0)
			$display("midpoint_ellipse_points regression: pass");
		else
			$display("midpoint_ellipse_points regression: fail");
		$finish;
	end

endmodule

FILE: midpoint_ellipse_points.f
+incdir+rtl/core
rtl/core/mep_pkg.sv
rtl/core/mep_datapath.sv
rtl/core/mep_ctrl.sv
rtl/core/midpoint_ellipse_points.sv
test/midpoint_ellipse_points_tb.sv
